[design/ili_pkg.sv]
// shared types and codes for the indexed list block
package ili_pkg;

    localparam int DATA_W = 32;
    localparam int EXT_W  = 9;

    typedef logic [EXT_W-1:0]  t_ext;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [2:0]        t_req;
    typedef logic [1:0]        t_status;
    typedef logic [1:0]        t_cell_op;

    localparam t_req REQ_GET    = 3'd0;
    localparam t_req REQ_HEAD   = 3'd1;
    localparam t_req REQ_TAIL   = 3'd2;
    localparam t_req REQ_INDEX  = 3'd3;
    localparam t_req REQ_DELETE = 3'd4;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_cell_op CELL_HOLD = 2'd0;
    localparam t_cell_op CELL_GET  = 2'd1;
    localparam t_cell_op CELL_INS  = 2'd2;
    localparam t_cell_op CELL_DEL  = 2'd3;

    typedef struct packed {
        t_cell_op op;
        t_ext     pos;
        t_data    value;
    } t_cell_ctl;

endpackage

[design/ili_if.sv]
// request and result channel interfaces
interface ili_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [7:0]         position;
    logic signed [31:0] item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input item_value,
                    output ready);
endinterface

interface ili_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [5:0]         list_length;

    modport source (output valid, output read_value, output status, output list_length,
                    input ready);
    modport sink   (input valid, input read_value, input status, input list_length,
                    output ready);
endinterface

[design/ili_cell.sv]
// one list entry: holds, shifts from a neighbor, or takes a new value
module ili_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ili_pkg::t_cell_ctl  i_ctl,
    input  ili_pkg::t_data      i_left,
    input  ili_pkg::t_data      i_right,
    output ili_pkg::t_data      o_value,
    output ili_pkg::t_data      o_rd
);
    import ili_pkg::*;

    localparam t_ext MY_IDX = t_ext'(IDX);

    t_data r_value;
    t_data n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_INS: begin
                if (MY_IDX == i_ctl.pos) begin
                    n_value = i_ctl.value;
                end else if (MY_IDX > i_ctl.pos) begin
                    n_value = i_left;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_rd    = (i_ctl.op == CELL_GET && i_ctl.pos == MY_IDX) ? r_value : '0;

endmodule

[design/indexed_list_insert_delete.sv]
// indexed list top level: request sequencer, cell chain and result register
//
// Ordered list of up to CAPACITY signed 32-bit entries with a length count.
// Requests arrive on i_req (get, add at head, add at tail, add at index,
// delete at index); one result word per request leaves on o_rsp.
// Each request passes an accept cycle, an execute cycle in which every cell
// of the chain shifts or loads at once and the get data is gathered into
// registered groups of eight, and a finish step that merges the groups into
// the result register. o_rsp.valid rises when the finish step loads the result
// register; a new request is taken only after the previous one has finished.
// The result register decouples the sides: a request is accepted while a
// result still waits, and the finish step waits while the receiver stalls,
// so nothing is lost. Results come out in request order.
// Reset clears every entry and the length at once; i_req.ready is high in
// the first cycle after reset.
// Insert past the end appends, insert into a full list reports full, get and
// delete beyond the length report out of range, unknown codes change nothing.
module indexed_list_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ili_req_if.sink   i_req,
    ili_rsp_if.source o_rsp
);
    import ili_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int NG = (CAPACITY + 7) / 8;
    localparam t_ext CAP_X = t_ext'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    r_state, n_state;
    t_req          r_req;
    logic [7:0]    r_pos;
    t_data         r_val;
    logic [LW-1:0] r_len, n_len;
    t_status       r_stat, n_stat;
    logic          r_miss, n_miss;
    t_data         r_grp [NG];

    logic          r_out_valid;
    t_data         r_out_rd;
    t_status       r_out_stat;
    logic [5:0]    r_out_len;

    t_cell_ctl     ctl;
    t_ext          pos_x;
    t_ext          len_x;
    t_ext          ins_pos;
    logic          full;
    t_data         cell_q  [CAPACITY];
    t_data         cell_rd [NG*8];
    t_data         merged;
    logic          fin_go;

    assign pos_x   = t_ext'(r_pos);
    assign len_x   = t_ext'(r_len);
    assign full    = (len_x == CAP_X);
    assign ins_pos = (pos_x > len_x) ? len_x : pos_x;

    // decode the held request into a chain command, only in the execute cycle
    always_comb begin
        ctl.op    = CELL_HOLD;
        ctl.pos   = '0;
        ctl.value = r_val;
        n_stat    = ST_DONE;
        n_miss    = 1'b0;
        n_len     = r_len;
        case (r_req)
            REQ_GET: begin
                ctl.pos = pos_x;
                if (pos_x < len_x) begin
                    ctl.op = CELL_GET;
                end else begin
                    n_stat = ST_RANGE;
                    n_miss = 1'b1;
                end
            end
            REQ_HEAD, REQ_TAIL, REQ_INDEX: begin
                if (r_req == REQ_HEAD) begin
                    ctl.pos = '0;
                end else if (r_req == REQ_TAIL) begin
                    ctl.pos = len_x;
                end else begin
                    ctl.pos = ins_pos;
                end
                if (full) begin
                    n_stat = ST_FULL;
                end else begin
                    ctl.op = CELL_INS;
                    n_len  = r_len + LW'(1);
                end
            end
            REQ_DELETE: begin
                ctl.pos = pos_x;
                if (pos_x < len_x) begin
                    ctl.op = CELL_DEL;
                    n_len  = r_len - LW'(1);
                end else begin
                    n_stat = ST_RANGE;
                end
            end
            default: ctl.op = CELL_HOLD;
        endcase
        if (r_state != S_EXEC) begin
            ctl.op = CELL_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_data left_v, right_v;
            if (gi == 0) begin : g_first
                assign left_v = '0;
            end else begin : g_mid_l
                assign left_v = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_v = '0;
            end else begin : g_mid_r
                assign right_v = cell_q[gi+1];
            end
            ili_cell #(.IDX(gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_left  (left_v),
                .i_right (right_v),
                .o_value (cell_q[gi]),
                .o_rd    (cell_rd[gi])
            );
        end
        for (gi = CAPACITY; gi < NG*8; gi++) begin : g_pad
            assign cell_rd[gi] = '0;
        end
        // first level of the get gather, registered per group of eight
        for (gi = 0; gi < NG; gi++) begin : g_grp
            t_data n_grp;
            always_comb begin
                n_grp = '0;
                for (int k = 0; k < 8; k++) begin
                    n_grp = n_grp | cell_rd[gi*8+k];
                end
            end
            always_ff @(posedge i_clk) begin
                if (r_state == S_EXEC) begin
                    r_grp[gi] <= n_grp;
                end
            end
        end
    endgenerate

    always_comb begin
        merged = '0;
        for (int g = 0; g < NG; g++) begin
            merged = merged | r_grp[g];
        end
    end

    assign fin_go = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_EXEC;
            S_EXEC:  n_state = S_FIN;
            S_FIN:   if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_len <= n_len;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_req <= i_req.req_type;
            r_pos <= i_req.position;
            r_val <= t_data'(i_req.item_value);
        end
        if (r_state == S_EXEC) begin
            r_stat <= n_stat;
            r_miss <= n_miss;
        end
        if (fin_go) begin
            r_out_rd   <= r_miss ? '1 : merged;
            r_out_stat <= r_stat;
            r_out_len  <= len_x[5:0];
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_rd;
    assign o_rsp.status      = r_out_stat;
    assign o_rsp.list_length = r_out_len;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_ext'(r_len) <= CAP_X)
        else $error("list length beyond capacity");

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> (r_len == $past(r_len)))
        else $error("length changed outside execute cycle");

    a_full_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && full && (r_req == REQ_HEAD || r_req == REQ_TAIL ||
         r_req == REQ_INDEX)) |=> (r_len == $past(r_len) && r_stat == ST_FULL))
        else $error("insert into full list changed length");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish step");

    a_miss_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && r_miss) |=> (o_rsp.status == ST_RANGE && o_rsp.read_value == -32'sd1))
        else $error("get miss result malformed");

endmodule

[dv/testbench.sv]
// self-checking testbench for the indexed list block: stimulus, list predictor and result check
`timescale 1ns / 1ps

module testbench;
    import ili_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 150;
    localparam int TAIL_CYCLES  = 20;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    typedef struct {
        t_req               req_type;
        logic [7:0]         position;
        logic signed [31:0] item_value;
        bit                 drain;
    } t_request;

    typedef struct {
        logic signed [31:0] read_value;
        t_status            status;
        logic [5:0]         list_length;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ili_req_if req_ch ();
    ili_rsp_if rsp_ch ();

    indexed_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted list contents and length
    logic signed [31:0] list_entries [CAPACITY];
    int                 list_count;

    t_request pending_q [$];
    t_result  expected_q [$];
    t_request cur_req;

    int error_count  = 0;
    int results_seen = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int idle_cycles  = 0;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic insert_entry(input int pos, input logic signed [31:0] value,
                                output t_status st);
        if (list_count >= CAPACITY) begin
            st = ST_FULL;
        end else begin
            if (pos > list_count)
                pos = list_count;
            for (int i = list_count; i > pos; i--)
                list_entries[i] = list_entries[i-1];
            list_entries[pos] = value;
            list_count++;
            st = ST_DONE;
        end
    endtask

    task automatic apply_request(input t_request rq, output t_result res);
        int pos;
        pos = int'(rq.position);
        res.read_value = '0;
        res.status     = ST_DONE;
        case (rq.req_type)
            REQ_GET: begin
                if (pos < list_count) begin
                    res.read_value = list_entries[pos];
                end else begin
                    res.read_value = -1;
                    res.status     = ST_RANGE;
                end
            end
            REQ_HEAD:  insert_entry(0, rq.item_value, res.status);
            REQ_TAIL:  insert_entry(list_count, rq.item_value, res.status);
            REQ_INDEX: insert_entry(pos, rq.item_value, res.status);
            REQ_DELETE: begin
                if (pos >= list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i+1];
                    list_count--;
                    list_entries[list_count] = '0;
                end
            end
            default: ;
        endcase
        res.list_length = list_count[5:0];
    endtask

    function automatic t_request make_request(input t_req kind, input int pos,
                                              input logic signed [31:0] value);
        t_request rq;
        rq.req_type   = kind;
        rq.position   = pos[7:0];
        rq.item_value = value;
        rq.drain      = 1'b0;
        return rq;
    endfunction

    function automatic t_request random_request(input t_mix mix);
        int     roll;
        int     add_pct;
        int     del_pct;
        t_req   kind;
        int     pos;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   begin add_pct = 60; del_pct = 12; end
            MIX_SHRINK: begin add_pct = 15; del_pct = 55; end
            default:    begin add_pct = 35; del_pct = 35; end
        endcase
        if (roll < 4)
            kind = t_req'($urandom_range(5, 7));
        else if (roll < 4 + add_pct)
            case ($urandom_range(0, 2))
                0:       kind = REQ_HEAD;
                1:       kind = REQ_TAIL;
                default: kind = REQ_INDEX;
            endcase
        else if (roll < 4 + add_pct + del_pct)
            kind = REQ_DELETE;
        else
            kind = REQ_GET;
        // mostly positions near the live range, sometimes anywhere
        if ($urandom_range(0, 3) == 0)
            pos = $urandom_range(0, 255);
        else
            pos = $urandom_range(0, CAPACITY + 3);
        return make_request(kind, pos, $urandom);
    endfunction

    // reset and stimulus
    initial begin
        t_mix     mix;
        int       seg_left;
        t_request rq;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_GET;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        rsp_ch.ready      = 1'b0;
        list_count        = 0;
        foreach (list_entries[i])
            list_entries[i] = '0;

        // empty list corners, value extremes, every code, range repairs
        pending_q.push_back(make_request(REQ_GET,    0,   32'sd0));
        pending_q.push_back(make_request(REQ_DELETE, 0,   32'sd0));
        pending_q.push_back(make_request(REQ_INDEX,  255, 32'sd17));
        pending_q.push_back(make_request(REQ_HEAD,   255, 32'sh8000_0000));
        pending_q.push_back(make_request(REQ_TAIL,   0,   32'sh7fff_ffff));
        pending_q.push_back(make_request(REQ_INDEX,  1,   -32'sd1));
        pending_q.push_back(make_request(REQ_INDEX,  4,   32'sd0));
        pending_q.push_back(make_request(REQ_GET,    0,   32'sd0));
        pending_q.push_back(make_request(REQ_GET,    4,   32'sd0));
        pending_q.push_back(make_request(REQ_GET,    5,   32'sd0));
        pending_q.push_back(make_request(REQ_GET,    255, -32'sd1));
        pending_q.push_back(make_request(t_req'(5),  255, -32'sd1));
        pending_q.push_back(make_request(t_req'(6),  0,   32'sh5555_5555));
        pending_q.push_back(make_request(t_req'(7),  170, 32'shaaaa_aaaa));
        pending_q.push_back(make_request(REQ_DELETE, 255, 32'sd0));
        pending_q.push_back(make_request(REQ_DELETE, 5,   32'sd0));
        pending_q.push_back(make_request(REQ_DELETE, 0,   32'sd0));
        pending_q.push_back(make_request(REQ_DELETE, 3,   32'sd0));
        pending_q.push_back(make_request(REQ_INDEX,  0,   32'sh5555_5555));
        pending_q.push_back(make_request(REQ_GET,    2,   32'sd0));
        pending_q.push_back(make_request(REQ_DELETE, 1,   32'sd0));
        pending_q.push_back(make_request(REQ_GET,    1,   32'sd0));

        // random segments, each with a grow, shrink or even mix, push the list toward full or toward empty
        mix      = MIX_GROW;
        seg_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 120);
                case ($urandom_range(0, 2))
                    0:       mix = MIX_GROW;
                    1:       mix = MIX_SHRINK;
                    default: mix = MIX_EVEN;
                endcase
            end
            seg_left--;
            rq = random_request(mix);
            if (n % 300 == 0)
                rq.drain = 1'b1;
            pending_q.push_back(rq);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || req_ch.valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // request driver: bursts with random gaps, predicts on every accepted word
    always @(posedge i_clk) begin
        bit      fired;
        bit      next_valid;
        t_result exp_res;
        fired      = req_ch.valid && req_ch.ready;
        next_valid = req_ch.valid && !fired;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (fired) begin
                apply_request(cur_req, exp_res);
                expected_q.push_back(exp_res);
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0
                             && !(pending_q[0].drain && expected_q.size() > 0)) begin
                    cur_req = pending_q.pop_front();
                    req_ch.req_type   <= cur_req.req_type;
                    req_ch.position   <= cur_req.position;
                    req_ch.item_value <= cur_req.item_value;
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // result ready: changing stall patterns plus an occasional long hold
    int next_hold_at = 200;
    int hold_left    = 0;
    int pattern_left = 0;
    int pattern_mode = 0;
    int pattern_tick = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (results_seen >= next_hold_at) begin
            next_hold_at += 500;
            hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                pattern_mode = $urandom_range(0, 3);
            end
            pattern_left--;
            pattern_tick++;
            case (pattern_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= (pattern_tick % 4 == 0);
                default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result monitor: compare each word with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result word with no request outstanding");
            end else begin
                exp_res = expected_q.pop_front();
                if (rsp_ch.read_value !== exp_res.read_value)
                    report_mismatch($sformatf("read_value %0d, expected %0d",
                                              rsp_ch.read_value, exp_res.read_value));
                if (rsp_ch.status !== exp_res.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_ch.status, exp_res.status));
                if (rsp_ch.list_length !== exp_res.list_length)
                    report_mismatch($sformatf("list_length %0d, expected %0d",
                                              rsp_ch.list_length, exp_res.list_length));
            end
            results_seen++;
        end
    end

    // watchdog on cycles with work outstanding and no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (pending_q.size() == 0 && !req_ch.valid && expected_q.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

endmodule
